/* sv/spf_pkg.sv */
package spf_pkg;

  // Fixed widths of the coordinate fields and of the slope arithmetic
  localparam int XW   = 9;           // x, y and row fields
  localparam int FRAC = 16;          // fraction bits of the Q10.16 slope
  localparam int QW   = XW + FRAC;   // |dx| << 16, divider width
  localparam int SW   = QW + 1;      // signed slope
  localparam int AW   = QW + 2;      // signed x accumulator

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_RESP
  } spf_state_t;

endpackage

/* sv/scanline_polygon_span_fill.sv */
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  operation, start/end x and y, row_index
// out_     output     out_valid/out_stall span_row, span_left, span_right, has_pixels
//
// Clear: one table row written per cycle.
// Edge: a serial slope divide when the edge is not horizontal, then the row walk
//   (one row per cycle through the table read/write port pair).
// Read: the table row is read, then loaded into the output register once that is free.
// After reset the table is swept exactly as for a clear, in_stall high.
// in_stall is high whenever the sequencer is not idle; out_stall only holds the
//   output register and the read sequencer behind it.
module scanline_polygon_span_fill
  import spf_pkg::*;
#(
  parameter int ROWS = 512,
  parameter int COLS = 512
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [XW-1:0] in_start_x,
  input  logic [XW-1:0] in_start_y,
  input  logic [XW-1:0] in_end_x,
  input  logic [XW-1:0] in_end_y,
  input  logic [XW-1:0] in_row_index,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [XW-1:0] out_span_row,
  output logic [9:0]    out_span_left,
  output logic [XW-1:0] out_span_right,
  output logic          out_has_pixels
);

  localparam int RW = $clog2(ROWS);
  localparam int LW = $clog2(COLS + 1);
  localparam int CW = (LW > XW) ? LW : XW;

  spf_state_t state_r, state_nxt;
  logic [RW-1:0]        cnt_r, cnt_nxt;
  logic [XW:0]          y_r, y_nxt;
  logic [XW-1:0]        y2_r, y2_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] slope_r, slope_nxt;
  logic                 neg_r, neg_nxt;
  logic [XW-1:0]        row_r, row_nxt;
  logic                 st_vld_r, st_vld_nxt;
  logic [RW-1:0]        st_addr_r, st_addr_nxt;
  logic [XW-1:0]        st_xi_r, st_xi_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic [XW-1:0]        out_row_r, out_row_nxt;
  logic [9:0]           out_left_r, out_left_nxt;
  logic [XW-1:0]        out_right_r, out_right_nxt;
  logic                 out_has_r, out_has_nxt;

  logic                 mem_we, mem_re;
  logic [RW-1:0]        mem_waddr, mem_raddr;
  logic [LW-1:0]        mem_wleft, rd_left;
  logic [XW-1:0]        mem_wright, rd_right;

  logic                 div_start, div_done;
  logic [QW-1:0]        div_dividend, div_quotient;
  logic [XW-1:0]        div_divisor;

  logic                 swap;
  logic [XW-1:0]        xa, ya, xb, yb;
  logic signed [XW:0]   dx;
  logic [XW:0]          adx;
  logic                 issue;
  logic                 row_ok;
  logic [LW-1:0]        rsp_left;
  logic [XW-1:0]        rsp_right;
  logic signed [SW-1:0] quo_s;

  // order endpoints so that y rises along the walk
  assign swap = in_end_y < in_start_y;
  assign xa   = swap ? in_end_x   : in_start_x;
  assign ya   = swap ? in_end_y   : in_start_y;
  assign xb   = swap ? in_start_x : in_end_x;
  assign yb   = swap ? in_start_y : in_end_y;
  assign dx   = $signed({1'b0, xb}) - $signed({1'b0, xa});
  assign adx  = dx[XW] ? 10'(-dx) : 10'(dx);

  assign div_dividend = {adx[XW-1:0], {FRAC{1'b0}}};
  assign div_divisor  = yb - ya;
  assign quo_s        = $signed({1'b0, div_quotient});

  assign issue     = y_r <= {1'b0, y2_r};
  assign row_ok    = 32'(row_r) < ROWS;
  assign rsp_left  = row_ok ? rd_left : LW'(COLS);
  assign rsp_right = row_ok ? rd_right : '0;

  spf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  spf_table #(
    .ROWS (ROWS),
    .LW   (LW),
    .RTW  (XW)
  ) u_table (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wleft  (mem_wleft),
    .wright (mem_wright),
    .re     (mem_re),
    .raddr  (mem_raddr),
    .rleft  (rd_left),
    .rright (rd_right)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    y_nxt         = y_r;
    y2_nxt        = y2_r;
    acc_nxt       = acc_r;
    slope_nxt     = slope_r;
    neg_nxt       = neg_r;
    row_nxt       = row_r;
    st_vld_nxt    = 1'b0;
    st_addr_nxt   = st_addr_r;
    st_xi_nxt     = st_xi_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wleft     = LW'(COLS);
    mem_wright    = '0;
    mem_re        = 1'b0;
    mem_raddr     = st_addr_r;
    div_start     = 1'b0;
    out_vld_nxt   = out_vld_r && out_stall;
    out_row_nxt   = out_row_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_has_nxt   = out_has_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RW'(ROWS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            OP_EDGE: begin
              y_nxt   = {1'b0, ya};
              y2_nxt  = yb;
              acc_nxt = $signed({2'b00, xa, {FRAC{1'b0}}});
              neg_nxt = dx[XW];
              if (yb == ya) begin
                // one row only, the slope is never added in
                state_nxt = ST_WALK;
              end else begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            OP_READ: begin
              row_nxt   = in_row_index;
              mem_re    = 32'(in_row_index) < ROWS;
              mem_raddr = RW'(in_row_index);
              state_nxt = ST_RESP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slope_nxt = neg_r ? -quo_s : quo_s;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // stage holds the row read last cycle; write it back widened
        if (st_vld_r) begin
          mem_we     = 1'b1;
          mem_waddr  = st_addr_r;
          mem_wleft  = (CW'(st_xi_r) < CW'(rd_left)) ? LW'(st_xi_r) : rd_left;
          mem_wright = (st_xi_r > rd_right) ? st_xi_r : rd_right;
        end
        if (issue) begin
          st_vld_nxt  = 32'(y_r) < ROWS;
          st_addr_nxt = RW'(y_r[XW-1:0]);
          st_xi_nxt   = acc_r[QW-1:FRAC];
          mem_re      = st_vld_nxt;
          mem_raddr   = st_addr_nxt;
          y_nxt       = y_r + 1'b1;
          acc_nxt     = acc_r + {slope_r[SW-1], slope_r};
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (!out_vld_r || !out_stall) begin
          out_vld_nxt   = 1'b1;
          out_row_nxt   = row_r;
          out_left_nxt  = 10'(rsp_left);
          out_right_nxt = rsp_right;
          out_has_nxt   = CW'(rsp_left) < CW'(rsp_right);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cnt_r     <= '0;
      st_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      st_vld_r  <= st_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    y2_r        <= y2_nxt;
    acc_r       <= acc_nxt;
    slope_r     <= slope_nxt;
    neg_r       <= neg_nxt;
    row_r       <= row_nxt;
    st_addr_r   <= st_addr_nxt;
    st_xi_r     <= st_xi_nxt;
    out_row_r   <= out_row_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_has_r   <= out_has_nxt;
  end

  assign in_stall       = state_r != ST_IDLE;
  assign out_valid      = out_vld_r;
  assign out_span_row   = out_row_r;
  assign out_span_left  = out_left_r;
  assign out_span_right = out_right_r;
  assign out_has_pixels = out_has_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_we_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_WALK))
    else $error("table written outside clear or walk");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> (state_r == ST_DIV || state_r == ST_WALK))
    else $error("divide state left for something other than the walk");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == ST_RESP)
    else $error("result loaded without a read transaction");

endmodule

/* sv/spf_div.sv */
module spf_div
  import spf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [XW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CNW = $clog2(QW);

  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;
  logic [XW-1:0]  rem_r;
  logic [QW-1:0]  quo_r;
  logic [XW-1:0]  dvs_r;

  logic [XW:0] rem_sh;
  logic [XW:0] diff;
  logic        ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(QW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // divisor is held here, the input port moves on once the transaction is taken
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[XW-1:0] : rem_sh[XW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/spf_table.sv */
module spf_table #(
  parameter int ROWS = 512,
  parameter int LW   = 10,
  parameter int RTW  = 9
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [LW-1:0]           wleft,
  input  logic [RTW-1:0]          wright,
  input  logic                    re,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [LW-1:0]           rleft,
  output logic [RTW-1:0]          rright
);

  logic [LW-1:0]  left_mem  [ROWS];
  logic [RTW-1:0] right_mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      left_mem[waddr]  <= wleft;
      right_mem[waddr] <= wright;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rleft  <= left_mem[raddr];
      rright <= right_mem[raddr];
    end
  end

endmodule

/* dv/span_fill_checker.sv */
module span_fill_checker
  import spf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [XW-1:0] in_start_x,
  input  logic [XW-1:0] in_start_y,
  input  logic [XW-1:0] in_end_x,
  input  logic [XW-1:0] in_end_y,
  input  logic [XW-1:0] in_row_index,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [XW-1:0] out_span_row,
  input  logic [9:0]    out_span_left,
  input  logic [XW-1:0] out_span_right,
  input  logic          out_has_pixels,
  output int            fail_count,
  output int            spans_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 512;
  localparam int COLS = 512;

  typedef struct packed {
    logic [XW-1:0] row;
    logic [9:0]    left;
    logic [XW-1:0] right;
    logic          filled;
  } span_t;

  logic [9:0]    row_left  [ROWS];
  logic [XW-1:0] row_right [ROWS];
  span_t         spans_q   [$];
  int            faults = 0;

  function automatic void wipe_rows();
    for (int r = 0; r < ROWS; r++) begin
      row_left[r]  = 10'(COLS);
      row_right[r] = '0;
    end
  endfunction

  // Walk the edge bottom-up in Q11.16 and widen every row it crosses
  function automatic void widen_rows(int xa, int ya, int xb, int yb);
    longint dx, dy, slope, acc, xi;
    int t, y;
    if (yb < ya) begin
      t = ya; ya = yb; yb = t;
      t = xa; xa = xb; xb = t;
    end
    dx = longint'(xb - xa);
    dy = longint'(yb - ya);
    // signed division truncates toward zero, as the slope must
    slope = (dy != 0) ? (dx * 65536) / dy : dx * 65536;
    acc = longint'(xa) * 65536;
    for (y = ya; y <= yb; y++) begin
      xi = acc / 65536;  // acc never goes negative, so this is a floor
      if (y < ROWS) begin
        if (xi < longint'(row_left[y]))  row_left[y]  = 10'(xi);
        if (xi > longint'(row_right[y])) row_right[y] = XW'(xi);
      end
      acc += slope;
    end
  endfunction

  function automatic span_t span_of(int row);
    span_t s;
    s.row   = XW'(row);
    s.left  = 10'(COLS);
    s.right = '0;
    if (row < ROWS) begin
      s.left  = row_left[row];
      s.right = row_right[row];
    end
    s.filled = (s.left < {1'b0, s.right});
    return s;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", what, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    span_t want;
    if (!rst_n) begin
      wipe_rows();
      spans_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (spans_q.size() == 0) begin
          $error("span transaction with none expected, row %0d", out_span_row);
          faults++;
        end else begin
          want = spans_q.pop_front();
          check_field("span_row", 32'(want.row), 32'(out_span_row));
          check_field("span_left", 32'(want.left), 32'(out_span_left));
          check_field("span_right", 32'(want.right), 32'(out_span_right));
          check_field("has_pixels", 32'(want.filled), 32'(out_has_pixels));
        end
      end
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_CLEAR: wipe_rows();
          OP_EDGE:  widen_rows(int'(in_start_x), int'(in_start_y),
                               int'(in_end_x), int'(in_end_y));
          OP_READ:  spans_q.push_back(span_of(int'(in_row_index)));
          default: ;
        endcase
      end
    end
    fail_count <= faults;
    spans_due  <= spans_q.size();
  end

endmodule

/* dv/scanline_polygon_span_fill_tb.sv */
module scanline_polygon_span_fill_tb
  import spf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEMS          = 750;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         SETTLE_CYCLES  = 600;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam logic [1:0] OP_NOP         = 2'd3;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_operation = OP_CLEAR;
  logic [XW-1:0] in_start_x = '0;
  logic [XW-1:0] in_start_y = '0;
  logic [XW-1:0] in_end_x = '0;
  logic [XW-1:0] in_end_y = '0;
  logic [XW-1:0] in_row_index = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [XW-1:0] out_span_row;
  logic [9:0]    out_span_left;
  logic [XW-1:0] out_span_right;
  logic          out_has_pixels;
  int            fail_count;
  int            spans_due;

  int   idle_pct = 0;
  int   stall_pct = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  scanline_polygon_span_fill dut (.*);

  span_fill_checker chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: random stalls, or a long hold-off each time hold_req toggles
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[scanline_polygon_span_fill] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_coord();
    return int'($urandom_range(511));
  endfunction

  task automatic send(logic [1:0] op, int sx, int sy, int ex, int ey, int row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_start_x   <= XW'(sx);
    in_start_y   <= XW'(sy);
    in_end_x     <= XW'(ex);
    in_end_y     <= XW'(ey);
    in_row_index <= XW'(row);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_NOP) items_sent++;
  endtask

  task automatic read_row(int row);
    send(OP_READ, pick_coord(), pick_coord(), pick_coord(), pick_coord(), row);
  endtask

  task automatic drain_spans();
    in_valid <= 1'b0;
    @(posedge clk);
    while (spans_due != 0) @(posedge clk);
  endtask

  // Reads pile up behind a held output until the block stalls its input
  task automatic hold_off_burst();
    int i;
    hold_req <= ~hold_req;
    for (i = 0; i < 10; i++) begin
      if (i == 4) send(OP_EDGE, pick_coord(), pick_coord(), pick_coord(), pick_coord(), 0);
      else read_row(pick_coord());
    end
    drain_spans();
  endtask

  // Optional clear, then a closed polygon, mostly in a small box, then reads mostly across its rows
  task automatic draw_polygon();
    int n, box, ox, oy, y_lo, y_hi, reads, i, r, row;
    int vx[6];
    int vy[6];
    n = $urandom_range(6, 3);
    box = ($urandom_range(3) == 0) ? 511 : $urandom_range(64, 2);
    ox = $urandom_range(511 - box);
    oy = $urandom_range(511 - box);
    y_lo = 511;
    y_hi = 0;
    for (i = 0; i < n; i++) begin
      vx[i] = ox + $urandom_range(box);
      vy[i] = oy + $urandom_range(box);
      if (vy[i] < y_lo) y_lo = vy[i];
      if (vy[i] > y_hi) y_hi = vy[i];
    end
    if ($urandom_range(1) == 0)
      send(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
    for (i = 0; i < n; i++)
      send(OP_EDGE, vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n], pick_coord());
    reads = $urandom_range(12, 4);
    for (i = 0; i < reads; i++) begin
      r = $urandom_range(99);
      if (r < 80)      row = $urandom_range(y_hi, y_lo);
      else if (r < 85) row = (y_lo > 0) ? y_lo - 1 : y_lo;
      else if (r < 90) row = (y_hi < 511) ? y_hi + 1 : y_hi;
      else             row = pick_coord();
      read_row(row);
    end
  endtask

  initial begin
    int block, next_switch, r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // untouched rows straight after the reset sweep
    read_row(0);
    send(OP_READ, 0, 0, 0, 0, 511);
    send(OP_EDGE, 0, 0, 511, 511, 0);
    send(OP_EDGE, 511, 0, 0, 511, 511);
    read_row(0);
    read_row(255);
    read_row(511);
    // flat edge: one row, only its first x lands
    send(OP_EDGE, 100, 300, 400, 300, 0);
    send(OP_EDGE, 7, 10, 7, 20, 0);
    // endpoints given top first, so they get swapped
    send(OP_EDGE, 300, 50, 20, 10, 0);
    read_row(300);
    read_row(15);
    read_row(30);
    send(OP_NOP, 511, 511, 511, 511, 511);
    read_row(300);
    send(OP_CLEAR, 511, 511, 511, 511, 511);
    read_row(0);
    read_row(300);
    read_row(511);
    // negative slope, truncated toward zero
    send(OP_EDGE, 10, 0, 0, 3, 0);
    read_row(1);
    read_row(2);
    read_row(3);
    hold_off_burst();

    block = 0;
    next_switch = items_sent;
    while (items_sent < ITEMS) begin
      if (items_sent >= next_switch) begin
        case (block % 4)
          0: begin idle_pct = 0;  stall_pct <= 0;  end
          1: begin idle_pct = 52; stall_pct <= 0;  end
          2: begin idle_pct = 0;  stall_pct <= 52; end
          default: begin idle_pct = 22; stall_pct <= 22; end
        endcase
        if (block == 6) hold_off_burst();
        block++;
        next_switch = items_sent + 60;
      end
      if ($urandom_range(99) < 70) begin
        draw_polygon();
      end else begin
        r = $urandom_range(99);
        if (r < 5)
          send(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
        else if (r < 10)
          send(OP_NOP, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
        else if (r < 50)
          send(OP_EDGE, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord());
        else
          read_row(pick_coord());
      end
    end

    drain_spans();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[scanline_polygon_span_fill] OK");
    end else begin
      $display("[scanline_polygon_span_fill] ERROR");
    end
    $finish;
  end

endmodule
